// File: sv/cee_pkg.sv
// Shared types, constants and fixed-point helpers for the complex expression evaluator.
// No dependencies; every other file in sv/ imports this package.
package cee_pkg;

	localparam int STACK_DEPTH   = 16;
	localparam int NUM_VARIABLES = 26;
	localparam int NEST_MAX      = 31;

	localparam int SCW   = $clog2(STACK_DEPTH + 1);
	localparam int LVW   = $clog2(NEST_MAX + 1);
	localparam int CMPW  = ((SCW > LVW) ? SCW : LVW) + 1;
	localparam int VAR_AW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

	localparam int OQ_DEPTH = 2;
	localparam int OQW      = $clog2(OQ_DEPTH + 1);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SYMBOL = 1'b1;

	// ASCII codes of the recognized characters
	localparam logic [7:0] CH_A     = 8'h61; // a
	localparam logic [7:0] CH_Z     = 8'h7A; // z
	localparam logic [7:0] CH_PLUS  = 8'h2B; // +
	localparam logic [7:0] CH_STAR  = 8'h2A; // *
	localparam logic [7:0] CH_OPEN  = 8'h28; // (
	localparam logic [7:0] CH_CLOSE = 8'h29; // )
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_STACK   = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	localparam logic [1:0] FLT_INVALID = 2'b01;
	localparam logic [1:0] FLT_STACK   = 2'b10;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic {OP_ADD, OP_MUL} op_t;

	typedef enum logic [1:0] {CELL_HOLD, CELL_PUSH, CELL_POP} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t vcmd;
		cell_cmd_t ocmd;
	} cell_ctl_t;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cval_t;

	typedef struct packed {
		logic               command;
		logic [4:0]         var_index;
		logic signed [31:0] value_re;
		logic signed [31:0] value_im;
		logic [7:0]         symbol;
		logic               end_of_expression;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result_re;
		logic signed [31:0] result_im;
		logic [1:0]         status;
	} result_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
		if (x[32] == x[31]) begin
			return $signed(x[31:0]);
		end else if (x[32]) begin
			return Q_MIN;
		end else begin
			return Q_MAX;
		end
	endfunction

	// floor((p +/- q) / 2^24), saturated to 32 bits
	function automatic logic signed [31:0] fuse24(input logic signed [63:0] p,
	                                              input logic signed [63:0] q,
	                                              input logic sub);
		logic signed [64:0] s;
		logic signed [64:0] sh;
		s  = sub ? (65'(p) - 65'(q)) : (65'(p) + 65'(q));
		sh = s >>> 24;
		if ((&sh[64:31]) || !(|sh[64:31])) begin
			return $signed(sh[31:0]);
		end else if (sh[64]) begin
			return Q_MIN;
		end else begin
			return Q_MAX;
		end
	endfunction

endpackage

// File: sv/cee_cell.sv
// One stack cell: a value entry and an operator entry that shift with their neighbors.
// Depends on cee_pkg (cval_t, op_t, cell_ctl_t).
module cee_cell import cee_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  cval_t     v_above,
	input  cval_t     v_below,
	input  op_t       o_above,
	input  op_t       o_below,
	output cval_t     v,
	output op_t       o
);

	cval_t v_q;
	op_t   o_q;

	always_ff @(posedge clk) begin
		case (ctl.vcmd)
			CELL_PUSH: v_q <= v_above;
			CELL_POP:  v_q <= v_below;
			default:   v_q <= v_q;
		endcase
		case (ctl.ocmd)
			CELL_PUSH: o_q <= o_above;
			CELL_POP:  o_q <= o_below;
			default:   o_q <= o_q;
		endcase
	end

	assign v = v_q;
	assign o = o_q;

endmodule

// File: sv/cee_cmul.sv
// Complex multiplier: four registered 32x32 products, then fused Q8.24 rescale.
// Depends on cee_pkg (cval_t, fuse24).
module cee_cmul import cee_pkg::*; (
	input  logic  clk,
	input  logic  load,
	input  cval_t a,
	input  cval_t b,
	output cval_t res
);

	logic signed [63:0] rr_s1;
	logic signed [63:0] ii_s1;
	logic signed [63:0] ir_s1;
	logic signed [63:0] ri_s1;

	always_ff @(posedge clk) begin
		if (load) begin
			rr_s1 <= 64'(a.re) * 64'(b.re);
			ii_s1 <= 64'(a.im) * 64'(b.im);
			ir_s1 <= 64'(a.im) * 64'(b.re);
			ri_s1 <= 64'(a.re) * 64'(b.im);
		end
	end

	always_comb begin
		res.re = fuse24(rr_s1, ii_s1, 1'b1);
		res.im = fuse24(ir_s1, ri_s1, 1'b0);
	end

endmodule

// File: sv/cee_outq.sv
// Two-entry result queue; the head entry drives the result port.
// Depends on cee_pkg (result_t, OQ_DEPTH, OQW).
module cee_outq import cee_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  result_t        din,
	input  logic           stall,
	output logic           valid,
	output result_t        dout,
	output logic [OQW-1:0] level
);

	result_t        e0_q;
	result_t        e1_q;
	logic [OQW-1:0] cnt_q;
	logic           pop;

	assign pop = (cnt_q != '0) && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + OQW'(push) - OQW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			e0_q <= (push && cnt_q == OQW'(1)) ? din : e1_q;
			if (push) begin
				e1_q <= din;
			end
		end else if (push) begin
			if (cnt_q == '0) begin
				e0_q <= din;
			end else begin
				e1_q <= din;
			end
		end
	end

	assign valid = (cnt_q != '0);
	assign dout  = e0_q;
	assign level = cnt_q;

endmodule

// File: sv/complex_expression_evaluator.sv
// Channel  Handshake              Beat
// cmd      cmd_valid / cmd_stall  item_t: load of a variable or one expression character
// res      res_valid / res_stall  result_t: top value and status at end of expression
//
// One beat per cycle while cmd_stall is low. For a symbol that completes a '*' combine,
// the multiplier registers its products and the top cell takes the result in the next cycle.
// Results leave through a two-entry queue, fed from the registered final-beat state.
// Reset clears the counters, fault flags and variable file; stack cells are not reset.
// cmd_stall rises during the multiply writeback and when the result queue has no room.
// Depends on cee_pkg, cee_cell, cee_cmul and cee_outq.
module complex_expression_evaluator import cee_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_stall,
	input  item_t   cmd,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res
);

	cval_t var_q [NUM_VARIABLES];

	logic [SCW-1:0] vc_q, vc_n;
	logic [SCW-1:0] oc_q, oc_n;
	logic [LVW-1:0] lvl_q, lvl_n;
	logic [1:0]     flt_q, flt_n;

	logic       emit_s1;
	logic       mul_s1;
	cval_t      top_s1;
	logic [1:0] status_s1;

	cval_t v [STACK_DEPTH];
	op_t   o [STACK_DEPTH];

	logic      accept, sym, end_go, mul_go;
	logic      is_open, is_close, is_add, is_mul, is_letter, is_space;
	logic      comb_close, comb_letter;
	logic [7:0] c;
	cval_t     var_val, opa, opb, sum, mul_res, top_in, top_nx;
	op_t       op_in;
	cell_cmd_t cmd0, cmdr, ocmd;
	logic [1:0] status_nx;

	logic [OQW-1:0] oq_cnt;
	logic           oq_pop;
	logic [OQW:0]   occ;
	result_t        oq_din;

	assign accept = cmd_valid && !cmd_stall;
	assign sym    = accept && (cmd.command == CMD_SYMBOL);
	assign end_go = sym && cmd.end_of_expression;
	assign c      = cmd.symbol;

	assign is_open   = (c == CH_OPEN);
	assign is_close  = (c == CH_CLOSE);
	assign is_add    = (c == CH_PLUS);
	assign is_mul    = (c == CH_STAR);
	assign is_space  = (c == CH_SPACE);
	assign is_letter = (c >= CH_A) && (c <= CH_Z) && ((c - CH_A) < 8'(NUM_VARIABLES));

	assign var_val = var_q[VAR_AW'(c - CH_A)];

	// on ')' the popped top is a and the value below it is b; on a letter, a is the variable and b the top
	assign opa = is_close ? v[0] : var_val;
	assign opb = is_close ? v[1] : v[0];

	always_comb begin
		sum.re = sat33(33'(opa.re) + 33'(opb.re));
		sum.im = sat33(33'(opa.im) + 33'(opb.im));
	end

	assign comb_close  = (CMPW'(oc_q) == CMPW'(lvl_q));
	assign comb_letter = (CMPW'(oc_q) == CMPW'(lvl_q) + CMPW'(1));

	always_comb begin
		vc_n   = vc_q;
		oc_n   = oc_q;
		lvl_n  = lvl_q;
		flt_n  = flt_q;
		cmd0   = CELL_HOLD;
		cmdr   = CELL_HOLD;
		ocmd   = CELL_HOLD;
		top_in = var_val;
		op_in  = is_mul ? OP_MUL : OP_ADD;
		mul_go = 1'b0;
		if (mul_s1) begin
			// write the product back into the top cell
			cmd0   = CELL_PUSH;
			top_in = mul_res;
		end else if (sym) begin
			if (is_open) begin
				if (lvl_q >= LVW'(NEST_MAX)) begin
					flt_n = flt_n | FLT_INVALID;
				end else begin
					lvl_n = lvl_q + LVW'(1);
				end
			end else if (is_close) begin
				if (lvl_q == '0) begin
					flt_n = flt_n | FLT_INVALID;
				end else begin
					lvl_n = lvl_q - LVW'(1);
					if (comb_close) begin
						oc_n = oc_q - SCW'(1);
						ocmd = CELL_POP;
						if (vc_q < SCW'(2)) begin
							flt_n = flt_n | FLT_STACK;
						end else begin
							vc_n = vc_q - SCW'(1);
							cmdr = CELL_POP;
							if (o[0] == OP_MUL) begin
								mul_go = 1'b1;
							end else begin
								cmd0   = CELL_PUSH;
								top_in = sum;
							end
						end
					end
				end
			end else if (is_add || is_mul) begin
				if (oc_q >= SCW'(STACK_DEPTH)) begin
					flt_n = flt_n | FLT_STACK;
				end else begin
					oc_n = oc_q + SCW'(1);
					ocmd = CELL_PUSH;
				end
			end else if (is_letter) begin
				if (vc_q >= SCW'(STACK_DEPTH)) begin
					flt_n = flt_n | FLT_STACK;
				end else begin
					vc_n = vc_q + SCW'(1);
					cmd0 = CELL_PUSH;
					cmdr = CELL_PUSH;
					if (comb_letter) begin
						oc_n = oc_q - SCW'(1);
						ocmd = CELL_POP;
						if (vc_q == '0) begin
							flt_n = flt_n | FLT_STACK;
						end else begin
							// pushed value and old top merge in place
							vc_n = vc_q;
							cmdr = CELL_HOLD;
							if (o[0] == OP_MUL) begin
								cmd0   = CELL_HOLD;
								mul_go = 1'b1;
							end else begin
								top_in = sum;
							end
						end
					end
				end
			end else if (!is_space) begin
				flt_n = flt_n | FLT_INVALID;
			end
		end

		if (vc_n == '0) begin
			top_nx = '0;
		end else if (cmd0 == CELL_PUSH) begin
			top_nx = top_in;
		end else begin
			top_nx = v[0];
		end

		if (flt_n[1]) begin
			status_nx = ST_STACK;
		end else if (vc_n == '0) begin
			status_nx = ST_EMPTY;
		end else if (flt_n[0]) begin
			status_nx = ST_INVALID;
		end else begin
			status_nx = ST_OK;
		end

		if (end_go) begin
			vc_n  = '0;
			oc_n  = '0;
			lvl_n = '0;
			flt_n = '0;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			cell_ctl_t ctl;
			cval_t     va, vb;
			op_t       oa, ob;
			assign ctl.vcmd = (gi == 0) ? cmd0 : cmdr;
			assign ctl.ocmd = ocmd;
			if (gi == 0) begin : g_head
				assign va = top_in;
				assign oa = op_in;
			end else begin : g_body
				assign va = v[gi-1];
				assign oa = o[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_tail
				assign vb = '0;
				assign ob = OP_ADD;
			end else begin : g_link
				assign vb = v[gi+1];
				assign ob = o[gi+1];
			end
			cee_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.v_above (va),
				.v_below (vb),
				.o_above (oa),
				.o_below (ob),
				.v       (v[gi]),
				.o       (o[gi])
			);
		end
	endgenerate

	cee_cmul u_cmul (
		.clk  (clk),
		.load (mul_go),
		.a    (opa),
		.b    (opb),
		.res  (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q    <= '0;
			oc_q    <= '0;
			lvl_q   <= '0;
			flt_q   <= '0;
			emit_s1 <= 1'b0;
			mul_s1  <= 1'b0;
			for (int i = 0; i < NUM_VARIABLES; i++) begin
				var_q[i] <= '0;
			end
		end else begin
			vc_q    <= vc_n;
			oc_q    <= oc_n;
			lvl_q   <= lvl_n;
			flt_q   <= flt_n;
			emit_s1 <= end_go;
			mul_s1  <= mul_go;
			if (accept && cmd.command == CMD_LOAD &&
			    cmd.var_index < 5'(NUM_VARIABLES)) begin
				var_q[VAR_AW'(cmd.var_index)] <= '{re: cmd.value_re, im: cmd.value_im};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (end_go) begin
			top_s1    <= top_nx;
			status_s1 <= status_nx;
		end
	end

	always_comb begin
		oq_din.result_re = mul_s1 ? mul_res.re : top_s1.re;
		oq_din.result_im = mul_s1 ? mul_res.im : top_s1.im;
		oq_din.status    = status_s1;
	end

	cee_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (emit_s1),
		.din    (oq_din),
		.stall  (res_stall),
		.valid  (res_valid),
		.dout   (res),
		.level  (oq_cnt)
	);

	// hold input while a product lands or the queue could overflow
	assign oq_pop    = res_valid && !res_stall;
	assign occ       = (OQW+1)'(oq_cnt) + (OQW+1)'(emit_s1) - (OQW+1)'(oq_pop);
	assign cmd_stall = mul_s1 || (occ >= (OQW+1)'(OQ_DEPTH));

`ifndef SYNTHESIS
	a_mul_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mul_go) |=> !accept)
		else $error("beat accepted during multiply writeback");

	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_s1 && !oq_pop) |-> (oq_cnt != OQW'(OQ_DEPTH)))
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vc_q <= SCW'(STACK_DEPTH)) && (oc_q <= SCW'(STACK_DEPTH)))
		else $error("stack count beyond depth");

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		end_go |=> (vc_q == '0) && (oc_q == '0) && (lvl_q == '0) && (flt_q == '0))
		else $error("expression state not cleared after final symbol");
`endif

endmodule
